// ===== hw/rtl/ftd_pkg.sv =====
// ----------------------------------------------------------------------------
// ftd_pkg
// Shared codes, field layout and job record for the task dispatcher.
// ----------------------------------------------------------------------------
package ftd_pkg;

  // Input commands (s_axis tuser)
  localparam logic [1:0] CMD_NEW    = 2'd0;
  localparam logic [1:0] CMD_DONE   = 2'd1;
  localparam logic [1:0] CMD_PASS   = 2'd2;

  // Result kinds (m_axis tuser)
  localparam logic [2:0] KIND_DISPATCH = 3'd0;
  localparam logic [2:0] KIND_CHANGE   = 3'd1;
  localparam logic [2:0] KIND_RESPONSE = 3'd2;
  localparam logic [2:0] KIND_QUEUED   = 3'd3;
  localparam logic [2:0] KIND_DROPPED  = 3'd4;
  localparam logic [2:0] KIND_PASS     = 3'd5;

  // State change codes
  localparam logic [1:0] CHG_INCREMENT = 2'd0;
  localparam logic [1:0] CHG_IDLE      = 2'd2;

  // Job modes: how many results a held job still produces
  localparam logic [1:0] MODE_ONE  = 2'd0;  // one precomputed result
  localparam logic [1:0] MODE_IDLE = 2'd1;  // idle change, response
  localparam logic [1:0] MODE_FILL = 2'd2;  // speed-up, dispatch from queue, response

  // Field widths
  localparam int unsigned TagW    = 16;
  localparam int unsigned CoreInW = 5;
  localparam int unsigned CoreOutW = 4;
  localparam int unsigned CfgW    = 5;

  // Stream layout
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned InTuserW  = 2;
  localparam int unsigned OutTdataW = 24;
  localparam int unsigned OutTuserW = 3;
  localparam int unsigned OutErrBit = 22;

  localparam logic [CfgW-1:0] CoresReset = 5'd16;

  typedef struct packed {
    logic [1:0]          mode;
    logic [2:0]          kind;
    logic [CoreOutW-1:0] core;
    logic [TagW-1:0]     tag;
    logic [1:0]          chg;
    logic                err;
  } ftd_job_t;

endpackage

// ===== hw/rtl/fifo_task_dispatcher_unit.sv =====
// ----------------------------------------------------------------------------
// fifo_task_dispatcher_unit
// Hands task tags to the lowest idle worker core, queueing them when none is.
// ----------------------------------------------------------------------------
// Input stream s_axis carries one command per transaction: tuser selects new
// request, completion or state change passthrough; tdata holds tag, core
// index and state code. Output stream m_axis carries the results: tuser is
// the kind, tlast marks the final result of an input transaction.
// cfg_wr_en_i/cfg_wr_data_i set the number of cores in use; write only idle.
// An accepted item updates the idle map and queue pointers at once and is
// held as a job; its results move from the job register into the output
// register. Requests, passthroughs and bad completions give one result and
// sustain one item per cycle while the receiver is ready. A completion gives
// two results, or three when a queued task is sent to the freed core, one
// per cycle through the output register while the receiver is ready. The
// queue head is read from the wait RAM as the completion is accepted.
// A stalled receiver holds the output register and the job; the next item is
// taken as soon as the job's last result moves into the output register.
// Reset marks every core idle, empties the queue and sets 16 cores in use;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module fifo_task_dispatcher_unit
  import ftd_pkg::*;
#(
  parameter int unsigned MAX_CORES   = 16,
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_wr_en_i,
  input  logic [CfgW-1:0]      cfg_wr_data_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [15:0] task_tag, [20:16] core_index, [22:21] state_code, [23] zero
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // [1:0] command
  input  logic [InTuserW-1:0]  s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [3:0] target_core, [19:4] result_tag, [21:20] change_code,
  // [22] index_error, [23] zero
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  // [2:0] kind
  output logic [OutTuserW-1:0] m_axis_tuser_o,
  output logic                 m_axis_tlast_o
);

  localparam int unsigned CoreW  = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int unsigned PtrW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned StoreW = (TAG_BITS < TagW) ? TAG_BITS : TagW;
  localparam int unsigned NumW   = 7;
  localparam logic [TagW-1:0] TagMask =
    (TAG_BITS >= TagW) ? {TagW{1'b1}} : TagW'((32'd1 << TAG_BITS) - 32'd1);

  // Input fields
  logic [1:0]         in_cmd;
  logic [TagW-1:0]    in_tag;
  logic [CoreInW-1:0] in_core;
  logic [1:0]         in_code;

  assign in_cmd  = s_axis_tuser_i;
  assign in_tag  = s_axis_tdata_i[15:0] & TagMask;
  assign in_core = s_axis_tdata_i[20:16];
  assign in_code = s_axis_tdata_i[22:21];

  // State
  logic [CfgW-1:0]      cores_q;
  logic [MAX_CORES-1:0] idle_q, idle_d;
  logic [PtrW-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]      count_q, count_d;
  ftd_job_t             job_q, job_d;
  logic                 job_vld_q, job_vld_d;
  logic [1:0]           step_q, step_d;
  logic                 out_vld_q, out_vld_d;
  logic [2:0]           out_kind_q;
  logic [CoreOutW-1:0]  out_core_q;
  logic [TagW-1:0]      out_tag_q;
  logic [1:0]           out_chg_q;
  logic                 out_err_q;
  logic                 out_last_q;

  // Control
  logic in_fire, out_free, emit_fire;
  logic ram_we, ram_re;
  logic [StoreW-1:0] ram_rdata;

  // Core search
  logic [NumW-1:0]      core_cnt;
  logic [MAX_CORES-1:0] active_mask, cand;
  logic                 found;
  logic [CoreW-1:0]     first;
  logic                 core_ok;
  logic [CoreW-1:0]     core_sel;
  logic                 queue_full, queue_empty;

  // Emitted result
  logic [2:0]          res_kind;
  logic [CoreOutW-1:0] res_core;
  logic [TagW-1:0]     res_tag;
  logic [1:0]          res_chg;
  logic                res_err;
  logic                res_last;

  assign core_cnt = (NumW'(cores_q) > NumW'(MAX_CORES)) ? NumW'(MAX_CORES)
                                                         : NumW'(cores_q);

  always_comb begin
    for (int c = 0; c < MAX_CORES; c++) begin
      active_mask[c] = NumW'(c) < core_cnt;
    end
  end

  assign cand  = idle_q & active_mask;
  assign found = |cand;

  // Lowest set bit wins
  always_comb begin
    first = '0;
    for (int c = MAX_CORES - 1; c >= 0; c--) begin
      if (cand[c]) begin
        first = CoreW'(c);
      end
    end
  end

  assign core_ok     = NumW'(in_core) < core_cnt;
  assign core_sel    = CoreW'(in_core);
  assign queue_full  = count_q >= CntW'(QUEUE_DEPTH);
  assign queue_empty = count_q == '0;

  // Handshake
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign emit_fire       = job_vld_q && out_free;
  assign s_axis_tready_o = !job_vld_q || (emit_fire && res_last);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign ram_we = in_fire && (in_cmd == CMD_NEW) && !found && !queue_full;
  assign ram_re = in_fire && (in_cmd == CMD_DONE) && core_ok && !queue_empty;

  // Decode an accepted transaction and update the dispatch state
  always_comb begin
    idle_d     = idle_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    job_d      = job_q;
    job_d.mode = MODE_ONE;
    job_d.kind = KIND_RESPONSE;
    job_d.core = '0;
    job_d.tag  = in_tag;
    job_d.chg  = '0;
    job_d.err  = 1'b0;
    case (in_cmd)
      CMD_NEW: begin
        if (found) begin
          idle_d[first] = 1'b0;
          job_d.kind    = KIND_DISPATCH;
          job_d.core    = CoreOutW'(first);
        end else if (!queue_full) begin
          tail_d     = (tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
          count_d    = count_q + 1'b1;
          job_d.kind = KIND_QUEUED;
        end else begin
          job_d.kind = KIND_DROPPED;
        end
      end
      CMD_DONE: begin
        if (!core_ok) begin
          job_d.err = 1'b1;
        end else begin
          job_d.core = CoreOutW'(in_core);
          if (!queue_empty) begin
            // freed core takes the queue head straight away
            idle_d[core_sel] = 1'b0;
            head_d     = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
            count_d    = count_q - 1'b1;
            job_d.mode = MODE_FILL;
          end else begin
            idle_d[core_sel] = 1'b1;
            job_d.mode       = MODE_IDLE;
          end
        end
      end
      CMD_PASS: begin
        job_d.kind = KIND_PASS;
        job_d.chg  = in_code;
      end
      default: ;
    endcase
  end

  // Result for the current step of the held job
  always_comb begin
    res_kind = job_q.kind;
    res_core = job_q.core;
    res_tag  = job_q.tag;
    res_chg  = job_q.chg;
    res_err  = job_q.err;
    res_last = 1'b1;
    case (job_q.mode)
      MODE_ONE: ;
      MODE_IDLE: begin
        if (step_q == 2'd0) begin
          res_kind = KIND_CHANGE;
          res_tag  = '0;
          res_chg  = CHG_IDLE;
          res_last = 1'b0;
        end else begin
          res_kind = KIND_RESPONSE;
          res_core = '0;
        end
      end
      MODE_FILL: begin
        if (step_q == 2'd0) begin
          res_kind = KIND_CHANGE;
          res_tag  = '0;
          res_chg  = CHG_INCREMENT;
          res_last = 1'b0;
        end else if (step_q == 2'd1) begin
          res_kind = KIND_DISPATCH;
          res_tag  = TagW'(ram_rdata);
          res_last = 1'b0;
        end else begin
          res_kind = KIND_RESPONSE;
          res_core = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    job_vld_d = job_vld_q;
    step_d    = step_q;
    if (emit_fire) begin
      step_d = step_q + 1'b1;
      if (res_last) begin
        job_vld_d = 1'b0;
      end
    end
    if (in_fire) begin
      // command 3 is swallowed without a result
      job_vld_d = (in_cmd == CMD_NEW) || (in_cmd == CMD_DONE) || (in_cmd == CMD_PASS);
      step_d    = '0;
    end
    out_vld_d = emit_fire ? 1'b1 : (out_vld_q && !m_axis_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cores_q   <= CoresReset;
      idle_q    <= '1;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      job_vld_q <= 1'b0;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        cores_q <= cfg_wr_data_i;
      end
      if (in_fire) begin
        idle_q  <= idle_d;
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
      end
      job_vld_q <= job_vld_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      job_q <= job_d;
    end
    if (emit_fire) begin
      out_kind_q <= res_kind;
      out_core_q <= res_core;
      out_tag_q  <= res_tag;
      out_chg_q  <= res_chg;
      out_err_q  <= res_err;
      out_last_q <= res_last;
    end
  end

  ftd_ram #(
    .Width (StoreW),
    .Depth (QUEUE_DEPTH)
  ) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (in_tag[StoreW-1:0]),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_err_q, out_chg_q, out_tag_q, out_core_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== hw/rtl/ftd_ram.sv =====
// ----------------------------------------------------------------------------
// ftd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ftd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ftd_checker.sv =====
// ----------------------------------------------------------------------------
// ftd_checker
// Port-level checks on the dispatcher's result stream.
// ----------------------------------------------------------------------------
module ftd_checker
  import ftd_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [OutTdataW-1:0] m_axis_tdata_o,
  input logic [OutTuserW-1:0] m_axis_tuser_o,
  input logic                 m_axis_tlast_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // Remaining results of a completion follow without a gap
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o)
    else $error("gap inside a completion burst");

  // A state change to a core always precedes a response
  a_change_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_CHANGE) |-> !m_axis_tlast_o)
    else $error("state change marked last");

  // Index error only on a lone response
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[OutErrBit] |->
      (m_axis_tuser_o == KIND_RESPONSE) && m_axis_tlast_o)
    else $error("index error on wrong result");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= KIND_PASS)
    else $error("unknown result kind");

endmodule

bind fifo_task_dispatcher_unit ftd_checker u_ftd_checker (.*);
